// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions of the span walker checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("span walker assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("span walker assertion failed");

`endif

// ===== rtl/core/tsaw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsaw_pkg
// Shared types and constants of the texture span address walker.
// ----------------------------------------------------------------------------
package tsaw_pkg;

   localparam int SPAN_FIELD_BITS = 12;
   localparam int TEX_SIZE_BITS   = 13;
   localparam int DIVIDEND_BITS   = 33;
   localparam int DIVISOR_BITS    = TEX_SIZE_BITS;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [TEX_SIZE_BITS-1:0] TEX_SIZE_MAX = 13'd4096;
   localparam logic [31:0] STEP_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] STEP_MIN = 32'h8000_0000;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_PITCH = 1'd1;

   typedef struct packed {
      logic                       op;
      logic [SPAN_FIELD_BITS-1:0] span_x_start;
      logic [SPAN_FIELD_BITS-1:0] span_x_end;
      logic [SPAN_FIELD_BITS-1:0] span_row;
      logic signed [31:0]         u_start;
      logic signed [31:0]         v_start;
      logic signed [31:0]         u_end;
      logic signed [31:0]         v_end;
      logic [31:0]                texture_base;
      logic [TEX_SIZE_BITS-1:0]   texture_width;
      logic [TEX_SIZE_BITS-1:0]   texture_height;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_address;
      logic [31:0] texel_address;
      logic        last_pixel;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/tsaw_div.sv =====
// ----------------------------------------------------------------------------
// tsaw_div
// Restoring divider, one quotient bit per cycle, shared by span setup.
// ----------------------------------------------------------------------------
module tsaw_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [tsaw_pkg::DIVIDEND_BITS-1:0]    dividend,
   input  logic [tsaw_pkg::DIVISOR_BITS-1:0]     divisor,
   output tsaw_pkg::div_stat_type                status,
   output logic [tsaw_pkg::DIVIDEND_BITS-1:0]    quotient,
   output logic [tsaw_pkg::DIVISOR_BITS-1:0]     remainder
);

   localparam int DVD_BITS = tsaw_pkg::DIVIDEND_BITS;
   localparam int DVS_BITS = tsaw_pkg::DIVISOR_BITS;
   localparam int CNT_BITS = $clog2(DVD_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DVD_BITS - 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [DVD_BITS-1:0] quo_ff;
   logic [DVD_BITS-1:0] quo_in;
   logic [DVS_BITS-1:0] rem_ff;
   logic [DVS_BITS-1:0] rem_in;
   logic [DVS_BITS-1:0] dvs_ff;
   logic [DVS_BITS:0]   rem_shift;
   logic [DVS_BITS:0]   rem_diff;
   logic                q_bit;

   // Shift in the next dividend bit, subtract when it fits.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_BITS-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      q_bit     = (rem_shift >= {1'b0, dvs_ff});
      rem_in    = q_bit ? rem_diff[DVS_BITS-1:0] : rem_shift[DVS_BITS-1:0];
      quo_in    = {quo_ff[DVD_BITS-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == LAST_STEP)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/core/texture_span_address_walker_unit.sv =====
// ----------------------------------------------------------------------------
// texture_span_address_walker_unit
// Affine span texture address walker in signed fixed point. A load transfer
// sets up one horizontal span; each tick transfer then yields the frame buffer
// address and the texel address of the next pixel, with the last pixel
// flagged. The block takes one item at a time. A tick goes from its transfer
// to its result in the output register through the wrap, multiply and sum
// steps, and waits before the sum while the output register holds a result
// the consumer has not yet taken. A load makes four passes of the shared
// restoring divider (start wrap of u and v, then the u and v steps), each with
// a divider start and pickup, then the row multiply and pixel address sum. A
// reversed load and a tick with no span in progress are dropped in the cycle
// of their transfer. A finished result waits in the output register while
// the next item is taken in.
// ----------------------------------------------------------------------------
module texture_span_address_walker_unit #(
   parameter int FRAC_BITS         = 16,
   parameter int SCREEN_COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration port
   input  logic                                 csr_write_en,
   input  logic [tsaw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                          csr_write_data,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tsaw_pkg::req_type                    req_payload,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tsaw_pkg::rsp_type                    rsp_payload
);

   localparam int SIZE_BITS  = tsaw_pkg::TEX_SIZE_BITS;
   localparam int FIELD_BITS = tsaw_pkg::SPAN_FIELD_BITS;
   // Coordinates are masked to the screen width, never wider than the field.
   localparam int COORD_BITS =
      (SCREEN_COORD_BITS < FIELD_BITS) ? SCREEN_COORD_BITS : FIELD_BITS;
   localparam int MUL_BITS   = 32 + SIZE_BITS + 1;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV_GO   = 3'd1;
   localparam logic [2:0] S_DIV_WAIT = 3'd2;
   localparam logic [2:0] S_PIX_MUL  = 3'd3;
   localparam logic [2:0] S_PIX_ADD  = 3'd4;
   localparam logic [2:0] S_T_WRAP   = 3'd5;
   localparam logic [2:0] S_T_MUL    = 3'd6;
   localparam logic [2:0] S_T_OUT    = 3'd7;

   // divider passes of a load, in order
   localparam logic [1:0] DIV_U_WRAP = 2'd0;
   localparam logic [1:0] DIV_V_WRAP = 2'd1;
   localparam logic [1:0] DIV_U_STEP = 2'd2;
   localparam logic [1:0] DIV_V_STEP = 2'd3;

   // Force a texture size into 1..4096.
   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] s);
      logic [SIZE_BITS-1:0] r;
      r = s;
      if (s == '0) begin
         r = SIZE_BITS'(1);
      end else if (s > tsaw_pkg::TEX_SIZE_MAX) begin
         r = tsaw_pkg::TEX_SIZE_MAX;
      end
      return r;
   endfunction

   // Magnitude of a signed 33-bit value; the most negative value never occurs.
   function automatic logic [32:0] mag33(input logic [32:0] x);
      return x[32] ? (~x + 33'd1) : x;
   endfunction

   // Bring an accumulator back into the texture with one add or one subtract.
   function automatic logic [31:0] tick_wrap(input logic [31:0] acc,
                                             input logic [SIZE_BITS-1:0] size);
      logic [31:0] m;
      logic [31:0] r;
      m = 32'({size, {FRAC_BITS{1'b0}}});
      r = acc;
      if (acc[31]) begin
         r = acc + m;
      end else if (acc >= m) begin
         r = acc - m;
      end
      return r;
   endfunction

   // configuration registers
   logic [31:0] frame_base_ff;
   logic [15:0] frame_pitch_ff;

   // sequencer and span state
   logic [2:0]           state_ff;
   logic [1:0]           div_idx_ff;
   logic                 active_ff;
   logic [SIZE_BITS-1:0] left_ff;
   logic [31:0]          u_acc_ff;
   logic [31:0]          v_acc_ff;
   logic [31:0]          u_step_ff;
   logic [31:0]          v_step_ff;
   logic [31:0]          pix_addr_ff;
   logic [31:0]          tex_base_ff;
   logic [SIZE_BITS-1:0] tex_w_ff;
   logic [SIZE_BITS-1:0] tex_h_ff;
   logic                 rsp_valid_ff;

   // load operands held for the setup passes
   logic [COORD_BITS-1:0] x0_ff;
   logic [COORD_BITS-1:0] len_ff;
   logic [COORD_BITS-1:0] row_ff;
   logic [31:0]           u0_ff;
   logic [31:0]           v0_ff;
   logic [31:0]           u1_ff;
   logic [31:0]           v1_ff;

   // tick and setup working registers
   logic [31:0]       prod_ff;
   logic [31:0]       u_int_ff;
   tsaw_pkg::rsp_type rsp_ff;

   // divider hookup
   logic                                div_start;
   logic [tsaw_pkg::DIVIDEND_BITS-1:0]  div_dividend;
   logic [tsaw_pkg::DIVISOR_BITS-1:0]   div_divisor;
   tsaw_pkg::div_stat_type              div_stat;
   logic [tsaw_pkg::DIVIDEND_BITS-1:0]  div_quo;
   logic [tsaw_pkg::DIVISOR_BITS-1:0]   div_rem;

   logic                  req_xfer;
   logic                  rsp_free;
   logic                  rsp_load;
   logic [COORD_BITS-1:0] in_x0;
   logic [COORD_BITS-1:0] in_x1;
   logic                  in_reversed;
   logic [31:0]           u0_int;
   logic [31:0]           v0_int;
   logic [32:0]           u_delta;
   logic [32:0]           v_delta;
   logic                  wrap_neg;
   logic [SIZE_BITS-1:0]  wrap_size;
   logic [FRAC_BITS-1:0]  wrap_frac;
   logic [SIZE_BITS-1:0]  wrap_int;
   logic [31:0]           wrap_val;
   logic                  step_neg;
   logic                  step_sat;
   logic [31:0]           step_val;
   logic [31:0]           v_int;
   logic [MUL_BITS-1:0]   v_row;
   logic                  last_in;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   // Take a new result when the output register is empty or being drained.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   // A finished pixel moves into the output register.
   assign rsp_load  = (state_ff == S_T_OUT) && rsp_free;

   assign in_x0       = req_payload.span_x_start[COORD_BITS-1:0];
   assign in_x1       = req_payload.span_x_end[COORD_BITS-1:0];
   assign in_reversed = (in_x1 < in_x0);

   // Floor of the start coordinates and the end-minus-start deltas.
   always_comb begin
      u0_int  = $signed(u0_ff) >>> FRAC_BITS;
      v0_int  = $signed(v0_ff) >>> FRAC_BITS;
      u_delta = {u1_ff[31], u1_ff} - {u0_ff[31], u0_ff};
      v_delta = {v1_ff[31], v1_ff} - {v0_ff[31], v0_ff};
   end

   // Route the operands of the current setup pass to the divider.
   always_comb begin
      case (div_idx_ff)
         DIV_U_WRAP: begin
            div_dividend = mag33({u0_int[31], u0_int});
            div_divisor  = tex_w_ff;
         end
         DIV_V_WRAP: begin
            div_dividend = mag33({v0_int[31], v0_int});
            div_divisor  = tex_h_ff;
         end
         DIV_U_STEP: begin
            div_dividend = mag33(u_delta);
            div_divisor  = SIZE_BITS'(len_ff);
         end
         default: begin
            div_dividend = mag33(v_delta);
            div_divisor  = SIZE_BITS'(len_ff);
         end
      endcase
   end

   assign div_start = (state_ff == S_DIV_GO);

   tsaw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Turn the integer remainder into a true modulo and put the fraction back.
   always_comb begin
      if (div_idx_ff == DIV_U_WRAP) begin
         wrap_neg  = u0_ff[31];
         wrap_size = tex_w_ff;
         wrap_frac = u0_ff[FRAC_BITS-1:0];
      end else begin
         wrap_neg  = v0_ff[31];
         wrap_size = tex_h_ff;
         wrap_frac = v0_ff[FRAC_BITS-1:0];
      end
      wrap_int = (wrap_neg && (div_rem != '0)) ? (wrap_size - div_rem) : div_rem;
      wrap_val = 32'({wrap_int, wrap_frac});
   end

   // Give the quotient its sign and saturate to the signed 32-bit range.
   always_comb begin
      step_neg = (div_idx_ff == DIV_U_STEP) ? u_delta[32] : v_delta[32];
      step_sat = |div_quo[32:31];
      if (len_ff == '0) begin
         step_val = '0;
      end else if (step_neg) begin
         step_val = step_sat ? tsaw_pkg::STEP_MIN : (~div_quo[31:0] + 32'd1);
      end else begin
         step_val = step_sat ? tsaw_pkg::STEP_MAX : div_quo[31:0];
      end
   end

   // Row offset of the texel: floor(v) times texture width.
   always_comb begin
      v_int   = $signed(v_acc_ff) >>> FRAC_BITS;
      v_row   = $signed(v_int) * $signed({1'b0, tex_w_ff});
      last_in = (left_ff <= SIZE_BITS'(1));
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff  <= '0;
         frame_pitch_ff <= 16'd320;
      end else if (csr_write_en) begin
         case (csr_index)
            tsaw_pkg::CSR_FRAME_BASE:  frame_base_ff  <= csr_write_data;
            tsaw_pkg::CSR_FRAME_PITCH: frame_pitch_ff <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and span state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_idx_ff   <= DIV_U_WRAP;
         active_ff    <= 1'b0;
         left_ff      <= '0;
         u_acc_ff     <= '0;
         v_acc_ff     <= '0;
         u_step_ff    <= '0;
         v_step_ff    <= '0;
         pix_addr_ff  <= '0;
         tex_base_ff  <= '0;
         tex_w_ff     <= SIZE_BITS'(1);
         tex_h_ff     <= SIZE_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished pixel, else drop the held result once it is taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  if (req_payload.op == tsaw_pkg::OP_LOAD) begin
                     // ignore a reversed span, keep any span in progress
                     if (!in_reversed) begin
                        tex_base_ff <= req_payload.texture_base;
                        tex_w_ff    <= clamp_size(req_payload.texture_width);
                        tex_h_ff    <= clamp_size(req_payload.texture_height);
                        div_idx_ff  <= DIV_U_WRAP;
                        state_ff    <= S_DIV_GO;
                     end
                  end else if (active_ff) begin
                     state_ff <= S_T_WRAP;
                  end
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_stat.done) begin
                  case (div_idx_ff)
                     DIV_U_WRAP: u_acc_ff  <= wrap_val;
                     DIV_V_WRAP: v_acc_ff  <= wrap_val;
                     DIV_U_STEP: u_step_ff <= step_val;
                     default:    v_step_ff <= step_val;
                  endcase
                  if (div_idx_ff == DIV_V_STEP) begin
                     state_ff <= S_PIX_MUL;
                  end else begin
                     div_idx_ff <= div_idx_ff + 2'd1;
                     state_ff   <= S_DIV_GO;
                  end
               end
            end
            S_PIX_MUL: begin
               state_ff <= S_PIX_ADD;
            end
            S_PIX_ADD: begin
               pix_addr_ff <= frame_base_ff + prod_ff + 32'(x0_ff);
               left_ff     <= SIZE_BITS'(len_ff) + SIZE_BITS'(1);
               active_ff   <= 1'b1;
               state_ff    <= S_IDLE;
            end
            S_T_WRAP: begin
               u_acc_ff <= tick_wrap(u_acc_ff, tex_w_ff);
               v_acc_ff <= tick_wrap(v_acc_ff, tex_h_ff);
               state_ff <= S_T_MUL;
            end
            S_T_MUL: begin
               // advance past this pixel; its floors are held in prod and u_int
               u_acc_ff <= u_acc_ff + u_step_ff;
               v_acc_ff <= v_acc_ff + v_step_ff;
               state_ff <= S_T_OUT;
            end
            default: begin
               // hold in S_T_OUT until the output register is free
               if (rsp_free) begin
                  pix_addr_ff <= pix_addr_ff + 32'd1;
                  if (last_in) begin
                     left_ff   <= '0;
                     active_ff <= 1'b0;
                  end else begin
                     left_ff <= left_ff - SIZE_BITS'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   // payload registers: load operands, products and the result
   always_ff @(posedge clock) begin
      if (req_xfer && (req_payload.op == tsaw_pkg::OP_LOAD) && !in_reversed) begin
         x0_ff  <= in_x0;
         len_ff <= in_x1 - in_x0;
         row_ff <= req_payload.span_row[COORD_BITS-1:0];
         u0_ff  <= req_payload.u_start;
         v0_ff  <= req_payload.v_start;
         u1_ff  <= req_payload.u_end;
         v1_ff  <= req_payload.v_end;
      end
      if (state_ff == S_PIX_MUL) begin
         prod_ff <= 32'(row_ff) * 32'(frame_pitch_ff);
      end else if (state_ff == S_T_MUL) begin
         prod_ff  <= v_row[31:0];
         u_int_ff <= $signed(u_acc_ff) >>> FRAC_BITS;
      end
      if (rsp_load) begin
         rsp_ff.pixel_address <= pix_addr_ff;
         rsp_ff.texel_address <= tex_base_ff + prod_ff + u_int_ff;
         rsp_ff.last_pixel    <= last_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/tsaw_checker.sv =====
// ----------------------------------------------------------------------------
// tsaw_checker
// Port-level checks of the texture span address walker, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsaw_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tsaw_pkg::rsp_type rsp_payload
);

   // leave reset empty and ready for a transfer
   `ASSERT_ALWAYS(a_reset_clean, clock, reset |=> (!rsp_valid && req_ready))

   // a new result is only made while the input side is closed
   `ASSERT_CLK(a_rsp_after_busy, clock, reset, $rose(rsp_valid) |-> !$past(req_ready))

   // hold a stalled result unchanged
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))

   // drop a result only after its transfer
   `ASSERT_CLK(a_rsp_no_drop, clock, reset, $fell(rsp_valid) |-> $past(rsp_ready))

endmodule

bind texture_span_address_walker_unit tsaw_checker u_tsaw_checker (.*);

// ===== verif/texture_span_address_walker_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_span_address_walker_unit_checker
// Watches the request, result and register ports of the span walker, keeps
// its own span walker state and compares every result transfer with the
// oldest predicted pixel.
// ----------------------------------------------------------------------------
module texture_span_address_walker_unit_checker
   import tsaw_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_write_data,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_payload,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        pixel_count
);

   logic [31:0]              frame_base_reg  = '0;
   logic [15:0]              frame_pitch_reg = 16'd320;

   logic                     walk_active = 1'b0;
   logic [TEX_SIZE_BITS-1:0] walk_left   = '0;
   logic [31:0]              u_acc       = '0;
   logic [31:0]              v_acc       = '0;
   logic [31:0]              u_inc       = '0;
   logic [31:0]              v_inc       = '0;
   logic [31:0]              pix_next    = '0;
   logic [31:0]              tex_base    = '0;
   logic [TEX_SIZE_BITS-1:0] tex_w       = 13'd1;
   logic [TEX_SIZE_BITS-1:0] tex_h       = 13'd1;

   rsp_type expected_pixels[$];
   int      mismatches = 0;
   int      compared   = 0;

   function automatic logic [TEX_SIZE_BITS-1:0] clamp_size(input logic [TEX_SIZE_BITS-1:0] s);
      if (s == '0) return 13'd1;
      if (s > TEX_SIZE_MAX) return TEX_SIZE_MAX;
      return s;
   endfunction

   // True modulo of the texture extent in fixed point.
   function automatic logic [31:0] wrap_into(input longint c, input logic [TEX_SIZE_BITS-1:0] s);
      longint m;
      longint r;
      m = longint'(s) << FRAC_BITS;
      r = c % m;
      if (r < 0) r += m;
      return r[31:0];
   endfunction

   // Per-pixel delta, truncated toward zero and saturated to 32 bits signed.
   function automatic logic [31:0] step_between(input longint a, input longint b,
                                                input longint n);
      longint q;
      if (n <= 0) return '0;
      q = (b - a) / n;
      if (q > longint'(STEP_MAX)) return STEP_MAX;
      if (q < -longint'(STEP_MAX) - 1) return STEP_MIN;
      return q[31:0];
   endfunction

   // One add or one subtract only, so a big step can leave the texture.
   function automatic longint fold_coord(input logic [31:0] acc,
                                         input logic [TEX_SIZE_BITS-1:0] s);
      longint m;
      longint c;
      m = longint'(s) << FRAC_BITS;
      c = longint'($signed(acc));
      if (c < 0) c += m;
      if (c >= m) c -= m;
      return c;
   endfunction

   task automatic predict_request(input req_type item);
      longint  u0;
      longint  v0;
      longint  span;
      longint  uc;
      longint  vc;
      longint  offset;
      rsp_type pixel;
      if (item.op == OP_LOAD) begin
         // drop reversed spans, the running span carries on
         if (item.span_x_end < item.span_x_start) return;
         u0   = longint'($signed(item.u_start));
         v0   = longint'($signed(item.v_start));
         span = longint'(item.span_x_end) - longint'(item.span_x_start);
         tex_w    = clamp_size(item.texture_width);
         tex_h    = clamp_size(item.texture_height);
         tex_base = item.texture_base;
         u_acc    = wrap_into(u0, tex_w);
         v_acc    = wrap_into(v0, tex_h);
         u_inc    = step_between(u0, longint'($signed(item.u_end)), span);
         v_inc    = step_between(v0, longint'($signed(item.v_end)), span);
         pix_next = frame_base_reg + 32'(item.span_row) * 32'(frame_pitch_reg)
                    + 32'(item.span_x_start);
         walk_left   = 13'(span + 1);
         walk_active = 1'b1;
      end else if (walk_active) begin
         uc = fold_coord(u_acc, tex_w);
         vc = fold_coord(v_acc, tex_h);
         offset = (vc >>> FRAC_BITS) * longint'(tex_w) + (uc >>> FRAC_BITS);
         pixel.pixel_address = pix_next;
         pixel.texel_address = tex_base + offset[31:0];
         pixel.last_pixel    = (walk_left <= 13'd1);
         expected_pixels.push_back(pixel);
         u_acc    = uc[31:0] + u_inc;
         v_acc    = vc[31:0] + v_inc;
         pix_next = pix_next + 32'd1;
         if (pixel.last_pixel) begin
            walk_left   = '0;
            walk_active = 1'b0;
         end else begin
            walk_left = walk_left - 13'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         frame_base_reg  = '0;
         frame_pitch_reg = 16'd320;
         walk_active     = 1'b0;
         walk_left       = '0;
         u_acc           = '0;
         v_acc           = '0;
         u_inc           = '0;
         v_inc           = '0;
         pix_next        = '0;
         tex_base        = '0;
         tex_w           = 13'd1;
         tex_h           = 13'd1;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected pixel: pix %h tex %h last %b", $realtime,
                           rsp_payload.pixel_address, rsp_payload.texel_address,
                           rsp_payload.last_pixel);
            end else begin
               want = expected_pixels.pop_front();
               compared++;
               if (rsp_payload.pixel_address !== want.pixel_address ||
                   rsp_payload.texel_address !== want.texel_address ||
                   rsp_payload.last_pixel !== want.last_pixel) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("[%0t] pixel %0d differs: want pix %h tex %h last %b, got pix %h tex %h last %b",
                              $realtime, compared, want.pixel_address, want.texel_address,
                              want.last_pixel, rsp_payload.pixel_address,
                              rsp_payload.texel_address, rsp_payload.last_pixel);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_BASE:  frame_base_reg  = csr_write_data;
               CSR_FRAME_PITCH: frame_pitch_reg = csr_write_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_request(req_payload);
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_pixels.size();
      pixel_count    <= compared;
   end

endmodule

// ===== verif/texture_span_address_walker_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_span_address_walker_unit_tb
// Drives span loads and pixel ticks into the span walker under random idle
// on both channels and across several frame buffer settings; the checker
// beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module texture_span_address_walker_unit_tb;
   import tsaw_pkg::*;

   localparam int ITEM_GOAL    = 1130;  // random part, on top of the directed part
   localparam int SETTLE_CYCLES = 200;  // a load gives no result while it runs its setup

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      csr_write_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = CSR_FRAME_BASE;
   logic [31:0]               csr_write_data = '0;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   req_type                   req_payload    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   rsp_type                   rsp_payload;

   logic idle_enabled = 1'b1;
   int   mismatch_count;
   int   pending_count;
   int   pixel_count;
   int   load_count = 0;
   int   tick_count = 0;

   texture_span_address_walker_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload)
   );

   texture_span_address_walker_unit_checker span_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .pixel_count    (pixel_count)
   );

   always #5 clock = ~clock;

   // Stall the result side about a quarter of the time unless idling is off.
   always @(posedge clock) begin
      rsp_ready <= idle_enabled ? ($urandom_range(99) >= 25) : 1'b1;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Place one item on the request channel and hold it until the transfer.
   task automatic send_request(input req_type item);
      while (idle_enabled && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, drain every predicted pixel, then let a trailing load finish.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both frame buffer registers back to back, block idle.
   task automatic write_frame_setup(input logic [31:0] base, input logic [15:0] pitch);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_FRAME_BASE;
      csr_write_data <= base;
      @(posedge clock);
      csr_index      <= CSR_FRAME_PITCH;
      csr_write_data <= {16'd0, pitch};
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type r;
      r.op             = logic'($urandom_range(1));
      r.span_x_start   = 12'($urandom_range(4095));
      r.span_x_end     = 12'($urandom_range(4095));
      r.span_row       = 12'($urandom_range(4095));
      r.u_start        = $urandom;
      r.v_start        = $urandom;
      r.u_end          = $urandom;
      r.v_end          = $urandom;
      r.texture_base   = $urandom;
      r.texture_width  = 13'($urandom_range(8191));
      r.texture_height = 13'($urandom_range(8191));
      return r;
   endfunction

   // Tick with junk in the unused fields.
   function automatic req_type make_tick();
      req_type r;
      r    = random_request();
      r.op = OP_TICK;
      return r;
   endfunction

   function automatic req_type make_load(input logic [11:0] x0, input logic [11:0] x1,
                                         input logic [11:0] row,
                                         input logic [31:0] u0, input logic [31:0] v0,
                                         input logic [31:0] u1, input logic [31:0] v1,
                                         input logic [31:0] base,
                                         input logic [12:0] w, input logic [12:0] h);
      req_type r;
      r.op             = OP_LOAD;
      r.span_x_start   = x0;
      r.span_x_end     = x1;
      r.span_row       = row;
      r.u_start        = u0;
      r.v_start        = v0;
      r.u_end          = u1;
      r.v_end          = v1;
      r.texture_base   = base;
      r.texture_width  = w;
      r.texture_height = h;
      return r;
   endfunction

   // Mix of wide random, near-texture and extreme coordinates.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return 32'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000;
         2:       return 32'($urandom_range(32'h003F_FFFF));
         default: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // Mostly small or power-of-two sizes, some out of range to hit the clamp.
   function automatic logic [12:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 13'($urandom_range(1, 64));
      if (r < 80) return 13'(1 << $urandom_range(12));
      return 13'($urandom_range(8191));
   endfunction

   // Load a span and tick through it; sometimes cut it short so that the
   // next load lands mid-span.
   task automatic random_span();
      logic [11:0] x0;
      int          len;
      int          kind;
      int          ticks;
      kind = $urandom_range(99);
      if (kind < 70)      len = $urandom_range(7);
      else if (kind < 95) len = $urandom_range(8, 40);
      else                len = $urandom_range(41, 4095);
      x0 = 12'($urandom_range(4095 - len));
      send_request(make_load(x0, 12'(x0 + len), 12'($urandom_range(4095)),
                             pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             $urandom, pick_size(), pick_size()));
      load_count++;
      ticks = len + 1;
      if (ticks > 48) ticks = $urandom_range(4, 12);
      else if ($urandom_range(9) == 0) ticks = $urandom_range(ticks - 1);
      repeat (ticks) begin
         send_request(make_tick());
         tick_count++;
      end
   endtask

   task automatic random_item();
      int          r;
      logic [11:0] x0;
      r = $urandom_range(99);
      if (r < 82) begin
         random_span();
      end else if (r < 90) begin
         // stray tick: ignored unless a cut-short span is still open
         send_request(make_tick());
      end else if (r < 95) begin
         // reversed span, must be dropped
         x0 = 12'($urandom_range(1, 4095));
         send_request(make_load(x0, 12'($urandom_range(x0 - 1)), 12'($urandom_range(4095)),
                                $urandom, $urandom, $urandom, $urandom, $urandom,
                                pick_size(), pick_size()));
      end else begin
         send_request(random_request());
      end
   endtask

   initial begin
      logic [31:0] phase_base[4];
      logic [15:0] phase_pitch[4];
      int          goal;
      phase_base  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0010_0000};
      phase_pitch = '{16'hFFFF, 16'd1, 16'($urandom_range(1, 65535)), 16'd640};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset frame settings.
      // Tick before any span: no pixel.
      send_request(make_tick());
      // Single pixel span at the far corner, biggest texture, extreme starts.
      send_request(make_load(12'd4095, 12'd4095, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0, 32'h0, 32'hFFFF_FFFF, 13'd4096, 13'd4096));
      send_request(make_tick());
      // Zero texture size taken as one, negative start.
      send_request(make_load(12'd0, 12'd2, 12'd0, 32'hFFFF_0000, 32'h0,
                             32'h0003_0000, 32'hFFF0_0000, 32'h0, 13'd0, 13'd0));
      repeat (3) send_request(make_tick());
      // Saturated steps both ways, oversize texture clamped.
      send_request(make_load(12'd100, 12'd101, 12'd7, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 13'd8191, 13'd4097));
      repeat (2) send_request(make_tick());
      // Reversed load mid-span is dropped; tick past the end gives nothing.
      send_request(make_load(12'd0, 12'd3, 12'd1, 32'h0, 32'h0, 32'h0003_0000, 32'h0001_8000,
                             32'h0000_1000, 13'd16, 13'd16));
      send_request(make_tick());
      send_request(make_load(12'd50, 12'd49, 12'd2, $urandom, $urandom, $urandom, $urandom,
                             $urandom, 13'd8, 13'd8));
      repeat (4) send_request(make_tick());
      // New load replaces a span in progress.
      send_request(make_load(12'd10, 12'd20, 12'd3, 32'h0000_8000, 32'h0002_0000,
                             32'h0009_0000, 32'hFFFE_0000, 32'h0000_2000, 13'd10, 13'd6));
      send_request(make_tick());
      send_request(make_load(12'd5, 12'd6, 12'd4, 32'hFFFF_FFFF, 32'h0004_FFFF,
                             32'h0005_0000, 32'h0, 32'h0000_3000, 13'd3, 13'd5));
      repeat (2) send_request(make_tick());

      // Random part in four frame settings; the second runs with no idling.
      for (int p = 0; p < 4; p++) begin
         idle_enabled <= (p != 1);
         settle_block();
         write_frame_setup(phase_base[p], phase_pitch[p]);
         goal = ITEM_GOAL * (p + 1) / 4;
         while (load_count + tick_count < goal) random_item();
      end

      settle_block();
      $display("Covered %0d span loads and %0d span ticks over five frame settings",
               load_count, tick_count);
      $display("with random idling on both channels; %0d pixels compared, %0d mismatches",
               pixel_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tsaw_pkg.sv
rtl/core/tsaw_div.sv
rtl/core/texture_span_address_walker_unit.sv
rtl/core/tsaw_checker.sv
verif/texture_span_address_walker_unit_checker.sv
verif/texture_span_address_walker_unit_tb.sv
